### rtl/partial_ipv4_address_parser_assert.svh
// assertion macros used by the checker file
`ifndef PARTIAL_IPV4_ADDRESS_PARSER_ASSERT_SVH
`define PARTIAL_IPV4_ADDRESS_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PIPAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PIPAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pipap_pkg.sv
`default_nettype none

package pipap_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned OCTET_W = 10;
    localparam int unsigned RUN_W   = 3;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

    localparam logic [OCTET_W-1:0] OCTET_MAX  = 10'd255;
    localparam logic [RUN_W-1:0]   DIGITS_MAX = 3'd3;

    typedef enum logic [2:0] {
        PH_START,
        PH_OCTET,
        PH_PORT_WS,
        PH_PORT_DIG,
        PH_SKIP
    } t_phase;

    typedef enum logic {
        REG_LOCAL_ADDRESS = 1'b0,
        REG_DEFAULT_PORT  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] code;
    } t_char_item;

    typedef struct packed {
        logic              status;
        logic [ADDR_W-1:0] ip_address;
        logic [PORT_W-1:0] port_number;
    } t_result;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

`default_nettype wire

### rtl/pipap_in_stage.sv
`default_nettype none

module pipap_in_stage (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [pipap_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                        i_take,
    output logic                             o_stall,
    output pipap_pkg::t_char_item            o_item
);

    logic                         r_valid;
    logic [pipap_pkg::CHAR_W-1:0] r_code;
    logic                         load;

    // held character not consumed this cycle blocks the next transfer
    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code <= i_char_code;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.code  = r_code;

endmodule

`default_nettype wire

### rtl/pipap_parse.sv
`default_nettype none

module pipap_parse (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [pipap_pkg::ADDR_W-1:0] i_cfg_data,
    input  wire logic                         i_take,
    input  wire logic [pipap_pkg::CHAR_W-1:0] i_code,
    output pipap_pkg::t_result                o_result
);

    logic [pipap_pkg::ADDR_W-1:0] r_local_address;
    logic [pipap_pkg::PORT_W-1:0] r_default_port;

    pipap_pkg::t_phase             r_phase, n_phase;
    logic [pipap_pkg::OCTET_W-1:0] r_octet, n_octet;
    logic [pipap_pkg::RUN_W-1:0]   r_run, n_run;
    logic [pipap_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [pipap_pkg::ADDR_W-1:0]  r_mask, n_mask;
    logic [pipap_pkg::PORT_W-1:0]  r_port, n_port;
    logic                          r_neg, n_neg;
    logic                          r_err, n_err;

    pipap_pkg::t_phase             eff_phase;
    logic [pipap_pkg::CHAR_W-1:0]  digit;
    logic [pipap_pkg::OCTET_W-1:0] octet_step;
    logic [pipap_pkg::PORT_W-1:0]  port_step;
    logic                          octet_ok;
    logic [pipap_pkg::ADDR_W-1:0]  addr_shift;
    logic [pipap_pkg::ADDR_W-1:0]  mask_shift;
    logic                          res_err;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
            r_default_port  <= '0;
        end else if (i_cfg_we) begin
            unique case (pipap_pkg::t_cfg_reg'(i_cfg_index))
                pipap_pkg::REG_LOCAL_ADDRESS: r_local_address <= i_cfg_data;
                pipap_pkg::REG_DEFAULT_PORT:
                    r_default_port <= i_cfg_data[pipap_pkg::PORT_W-1:0];
            endcase
        end
    end

    // first character behaves as though a dot preceded it
    assign eff_phase  = (r_phase == pipap_pkg::PH_START) ? pipap_pkg::PH_OCTET : r_phase;
    assign digit      = i_code - pipap_pkg::CHAR_ZERO;
    assign octet_step = (r_octet << 3) + (r_octet << 1) + {2'b00, digit};
    assign port_step  = (r_port << 3) + (r_port << 1) + {8'h00, digit};
    assign octet_ok   = (r_octet <= pipap_pkg::OCTET_MAX);
    assign addr_shift = {r_addr[pipap_pkg::ADDR_W-9:0], r_octet[7:0]};
    assign mask_shift = {r_mask[pipap_pkg::ADDR_W-9:0], 8'h00};

    // next state
    always_comb begin
        n_phase = r_phase;
        n_octet = r_octet;
        n_run   = r_run;
        n_addr  = r_addr;
        n_mask  = r_mask;
        n_port  = r_port;
        n_neg   = r_neg;
        n_err   = r_err;
        if (i_take) begin
            if (i_code == pipap_pkg::CHAR_NUL) begin
                n_phase = pipap_pkg::PH_START;
                n_octet = '0;
                n_run   = '0;
                n_addr  = '0;
                n_mask  = '1;
                n_port  = '0;
                n_neg   = 1'b0;
                n_err   = 1'b0;
            end else if (r_phase == pipap_pkg::PH_START && i_code == pipap_pkg::CHAR_DOT) begin
                n_phase = pipap_pkg::PH_OCTET;
            end else begin
                unique case (eff_phase)
                    pipap_pkg::PH_OCTET: begin
                        n_phase = pipap_pkg::PH_OCTET;
                        if (pipap_pkg::is_digit(i_code)) begin
                            n_octet = octet_step;
                            n_run   = r_run + 3'd1;
                            if (r_run == pipap_pkg::DIGITS_MAX) begin
                                n_err   = 1'b1;
                                n_phase = pipap_pkg::PH_SKIP;
                            end
                        end else if (i_code != pipap_pkg::CHAR_DOT &&
                                     i_code != pipap_pkg::CHAR_COLON) begin
                            n_err   = 1'b1;
                            n_phase = pipap_pkg::PH_SKIP;
                        end else if (!octet_ok) begin
                            n_err   = 1'b1;
                            n_phase = pipap_pkg::PH_SKIP;
                        end else begin
                            n_addr  = addr_shift;
                            n_mask  = mask_shift;
                            n_octet = '0;
                            n_run   = '0;
                            if (i_code == pipap_pkg::CHAR_COLON) begin
                                n_phase = pipap_pkg::PH_PORT_WS;
                            end
                        end
                    end
                    pipap_pkg::PH_PORT_WS: begin
                        if (pipap_pkg::is_space(i_code)) begin
                            n_phase = pipap_pkg::PH_PORT_WS;
                        end else if (i_code == pipap_pkg::CHAR_PLUS) begin
                            n_phase = pipap_pkg::PH_PORT_DIG;
                        end else if (i_code == pipap_pkg::CHAR_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = pipap_pkg::PH_PORT_DIG;
                        end else if (pipap_pkg::is_digit(i_code)) begin
                            n_port  = port_step;
                            n_phase = pipap_pkg::PH_PORT_DIG;
                        end else begin
                            n_phase = pipap_pkg::PH_SKIP;
                        end
                    end
                    pipap_pkg::PH_PORT_DIG: begin
                        if (pipap_pkg::is_digit(i_code)) begin
                            n_port = port_step;
                        end else begin
                            n_phase = pipap_pkg::PH_SKIP;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pipap_pkg::PH_START;
            r_octet <= '0;
            r_run   <= '0;
            r_addr  <= '0;
            r_mask  <= '1;
            r_port  <= '0;
            r_neg   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_octet <= n_octet;
            r_run   <= n_run;
            r_addr  <= n_addr;
            r_mask  <= n_mask;
            r_port  <= n_port;
            r_neg   <= n_neg;
            r_err   <= n_err;
        end
    end

    // result for a terminating character
    always_comb begin
        o_result = '0;
        if (eff_phase == pipap_pkg::PH_OCTET) begin
            // last octet still open: close it, no port text
            res_err                = !octet_ok;
            o_result.ip_address    = (r_local_address & mask_shift) | addr_shift;
            o_result.port_number   = r_default_port;
        end else begin
            res_err                = r_err;
            o_result.ip_address    = (r_local_address & r_mask) | r_addr;
            o_result.port_number   = r_neg ? (16'h0000 - r_port) : r_port;
        end
        o_result.status = res_err;
        if (res_err) begin
            o_result.ip_address  = '0;
            o_result.port_number = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/pipap_out_stage.sv
`default_nettype none

module pipap_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire pipap_pkg::t_result i_result,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output pipap_pkg::t_result      o_result,
    output logic                    o_full
);

    logic               r_head_valid;
    logic               r_skid_valid;
    pipap_pkg::t_result r_head;
    pipap_pkg::t_result r_skid;
    logic               pop;

    assign pop      = r_head_valid && !i_stall;
    assign o_valid  = r_head_valid;
    assign o_result = r_head;
    assign o_full   = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (pop && i_push) begin
                r_head_valid <= 1'b1;
            end else if (pop) begin
                r_head_valid <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= r_head_valid;
            end else begin
                r_head_valid <= r_head_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (pop && i_push) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
                r_skid <= i_result;
            end else begin
                r_head <= i_result;
            end
        end else if (pop) begin
            r_head <= r_skid;
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid <= i_result;
            end else begin
                r_head <= i_result;
            end
        end else begin
            r_head <= r_head;
        end
    end

endmodule

`default_nettype wire

### rtl/partial_ipv4_address_parser.sv
// Dotted IPv4 text parser: one character per transfer on the input channel,
// a NUL character closes the string and gives exactly one result (status,
// completed address, port); other characters give none. Octets missing from
// the text are filled from local_address, the port comes from the text after
// ':' or else from default_port. Each character sits in the input register,
// then the parse step updates the state registers and a NUL writes its result
// into a two-entry output buffer, so one character is taken every cycle while
// the output side keeps up. A NUL's result passes through the input register
// and then the output buffer before it is shown. The input side only stalls
// when a NUL is waiting and both output entries are full. The user must write
// configuration registers through the plain write port while the block is
// idle; the block itself does not enforce this. Index 0 local_address,
// index 1 default_port.
`default_nettype none

module partial_ipv4_address_parser (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [pipap_pkg::ADDR_W-1:0] i_cfg_data,
    // character channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [pipap_pkg::CHAR_W-1:0] i_char_code,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_status,
    output logic [pipap_pkg::ADDR_W-1:0]      o_ip_address,
    output logic [pipap_pkg::PORT_W-1:0]      o_port_number
);

    pipap_pkg::t_char_item item;
    pipap_pkg::t_result    step_result;
    pipap_pkg::t_result    out_result;
    logic                  is_nul;
    logic                  out_full;
    logic                  take;
    logic                  push;

    // a held character moves on unless it is a NUL with nowhere to go
    assign is_nul = (item.code == pipap_pkg::CHAR_NUL);
    assign take   = item.valid && !(is_nul && out_full);
    assign push   = take && is_nul;

    pipap_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_char_code (i_char_code),
        .i_take      (take),
        .o_stall     (o_in_stall),
        .o_item      (item)
    );

    // parse state, config registers and result formation
    pipap_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_code      (item.code),
        .o_result    (step_result)
    );

    // result register plus skid entry
    pipap_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_result),
        .o_full   (out_full)
    );

    assign o_status      = out_result.status;
    assign o_ip_address  = out_result.ip_address;
    assign o_port_number = out_result.port_number;

endmodule

`default_nettype wire

### rtl/pipap_checker.sv
`default_nettype none

`include "partial_ipv4_address_parser_assert.svh"

module pipap_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic                         o_status,
    input wire logic [pipap_pkg::ADDR_W-1:0] o_ip_address,
    input wire logic [pipap_pkg::PORT_W-1:0] o_port_number
);

    logic                                         out_wait;
    logic                                         err_out;
    logic                                         err_zero;
    logic [pipap_pkg::ADDR_W+pipap_pkg::PORT_W:0] payload;

    assign out_wait = o_out_valid && i_out_stall;
    assign err_out  = o_out_valid && o_status;
    assign err_zero = (o_ip_address == '0) && (o_port_number == '0);
    assign payload  = {o_status, o_ip_address, o_port_number};

    `PIPAP_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, out_wait, o_out_valid, "result dropped")
    `PIPAP_ASSERT_NEXT(a_payload_held, i_clk, i_rst_n, out_wait, $stable(payload), "payload moved")
    `PIPAP_ASSERT_NOW(a_error_fields_zero, i_clk, i_rst_n, err_out, err_zero, "error carries data")
    `PIPAP_ASSERT_NOW(a_stall_has_result, i_clk, i_rst_n, o_in_stall, o_out_valid, "stray stall")

endmodule

bind partial_ipv4_address_parser pipap_checker u_pipap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_ip_address  (o_ip_address),
    .o_port_number (o_port_number)
);

`default_nettype wire
